### design/sample_median_unit_defines.svh
// ----------------------------------------------------------------------------
// Sample median assertion macros
// Shared concurrent assertion forms for the sample median block.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MEDIAN_UNIT_DEFINES_SVH
`define SAMPLE_MEDIAN_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sample median same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SMU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sample median next-cycle check failed");

`endif

### design/smu_pkg.sv
// ----------------------------------------------------------------------------
// Sample median package
// Default sizes and the operation codes of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package smu_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	typedef logic alu_op_t;

	localparam alu_op_t ALU_ADD = 1'b0;
	localparam alu_op_t ALU_SUB = 1'b1;

endpackage

### design/smu_alu.sv
// ----------------------------------------------------------------------------
// Sample median shared arithmetic unit
// One sign-extended adder serves both the insertion compare and the
// floored half-sum of the two middle samples.
// ----------------------------------------------------------------------------
module smu_alu #(
	parameter int SAMPLE_BITS = smu_pkg::SAMPLE_BITS_DEF
) (
	input  smu_pkg::alu_op_t               op,
	input  logic signed [SAMPLE_BITS-1:0]  a,
	input  logic signed [SAMPLE_BITS-1:0]  b,
	output logic                           neg,
	output logic signed [SAMPLE_BITS-1:0]  half
);
	import smu_pkg::*;

	logic [SAMPLE_BITS:0] a_ext;
	logic [SAMPLE_BITS:0] b_ext;
	logic [SAMPLE_BITS:0] sum;

	assign a_ext = {a[SAMPLE_BITS-1], a};
	assign b_ext = (op == ALU_SUB) ? ~{b[SAMPLE_BITS-1], b} : {b[SAMPLE_BITS-1], b};
	assign sum   = a_ext + b_ext + {{SAMPLE_BITS{1'b0}}, (op == ALU_SUB)};

	// The extra bit keeps the sign exact, so dropping the low bit floors.
	assign neg  = sum[SAMPLE_BITS];
	assign half = sum[SAMPLE_BITS:1];

endmodule

### design/sample_median_unit.sv
// ----------------------------------------------------------------------------
// Sample median unit
// Keeps a set of signed samples in ascending order by insertion sort in an
// on-chip store and reports the median when the closing sample arrives.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  input     start / busy     sample, last
//  result    done (strobe)    median, count, overflow
//
//  A transaction is taken when start is high and busy is low. Inserting a
//  sample steps through the accept, then a read and a compare for each
//  stored sample that moves up and for the compare that stops the walk,
//  and then the write; a walk to the bottom skips the final compare. A
//  sample dropped on a full store skips the walk and the write. The closing
//  sample adds the read states MRD1 and MRD2, and an even count also the
//  sum state MSUM, set by the single read port of the store and the one
//  shared adder. done is high for one cycle and cannot be held off.
//  Reset empties the set; the store itself is not cleared.
// ----------------------------------------------------------------------------
`include "sample_median_unit_defines.svh"

module sample_median_unit #(
	parameter int MAX_SAMPLES = smu_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = smu_pkg::SAMPLE_BITS_DEF,
	localparam int CNT_W      = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	input  logic                           last,
	output logic                           done,
	output logic signed [SAMPLE_BITS-1:0]  median,
	output logic [CNT_W-1:0]               count,
	output logic                           overflow
);
	import smu_pkg::*;

	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_INS  = 3'd3;
	localparam logic [2:0] ST_MRD1 = 3'd4;
	localparam logic [2:0] ST_MRD2 = 3'd5;
	localparam logic [2:0] ST_MSUM = 3'd6;

	logic [2:0]                    state_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          last_q;
	logic [ADDR_W-1:0]             pos_q;
	logic [CNT_W-1:0]              fill_q;
	logic                          ovf_q;
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] median_q;
	logic [CNT_W-1:0]              count_q;
	logic                          overflow_q;
	logic                          done_q;

	logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	logic signed [SAMPLE_BITS-1:0] wr_data;
	logic [ADDR_W-1:0]             rd_addr;
	logic [ADDR_W-1:0]             half_idx;

	alu_op_t                       alu_op;
	logic signed [SAMPLE_BITS-1:0] alu_a;
	logic                          alu_neg;
	logic signed [SAMPLE_BITS-1:0] alu_half;

	logic                          accept;

	assign accept   = start && (state_q == ST_IDLE);
	assign half_idx = ADDR_W'(fill_q >> 1);

	smu_alu #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (rd_q),
		.neg (alu_neg),
		.half(alu_half)
	);

	// Store control: at most one write and one registered read per cycle.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = sample_q;
		rd_addr = pos_q - 1'b1;
		alu_op  = ALU_SUB;
		alu_a   = sample_q;
		case (state_q)
			ST_CMP: begin
				if (alu_neg) begin
					wr_en   = 1'b1;
					wr_data = rd_q;
				end
			end
			ST_INS: begin
				wr_en = 1'b1;
			end
			ST_MRD1: begin
				rd_addr = fill_q[0] ? half_idx : half_idx - 1'b1;
			end
			ST_MRD2: begin
				rd_addr = half_idx;
			end
			ST_MSUM: begin
				alu_op = ALU_ADD;
				alu_a  = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sample_q <= sample;
						last_q   <= last;
						if (fill_q < MAX_CNT) begin
							pos_q   <= ADDR_W'(fill_q);
							state_q <= (fill_q == '0) ? ST_INS : ST_READ;
						end else begin
							// Store full: the sample is dropped.
							ovf_q   <= 1'b1;
							state_q <= last ? ST_MRD1 : ST_IDLE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// A stored value above the new sample moves up one place.
					if (alu_neg) begin
						pos_q   <= pos_q - 1'b1;
						state_q <= (pos_q == ADDR_W'(1)) ? ST_INS : ST_READ;
					end else begin
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					fill_q  <= fill_q + 1'b1;
					state_q <= last_q ? ST_MRD1 : ST_IDLE;
				end
				ST_MRD1: begin
					state_q <= ST_MRD2;
				end
				ST_MRD2: begin
					if (fill_q[0]) begin
						median_q   <= rd_q;
						count_q    <= fill_q;
						overflow_q <= ovf_q;
						done_q     <= 1'b1;
						fill_q     <= '0;
						ovf_q      <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						a_q     <= rd_q;
						state_q <= ST_MSUM;
					end
				end
				ST_MSUM: begin
					median_q   <= alu_half;
					count_q    <= fill_q;
					overflow_q <= ovf_q;
					done_q     <= 1'b1;
					fill_q     <= '0;
					ovf_q      <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign median   = median_q;
	assign count    = count_q;
	assign overflow = overflow_q;

	`SMU_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= MAX_CNT)
	`SMU_ASSERT_SAME(a_done_clears, done_q, (fill_q == '0) && !ovf_q && (state_q == ST_IDLE))
	`SMU_ASSERT_SAME(a_done_count, done_q, (count_q != '0) && (count_q <= MAX_CNT))
	`SMU_ASSERT_NEXT(a_accept_busy, accept && ((fill_q < MAX_CNT) || last), busy)
	`SMU_ASSERT_NEXT(a_done_single, done_q, !done_q)

endmodule
